### rtl/ess_pkg.sv
// Shared types and constants for the ejector stroke sequencer.
package ess_pkg;

    // Operation codes carried in the operation field
    typedef logic [1:0] t_op;
    localparam t_op OP_TICK   = 2'd0;
    localparam t_op OP_HOLE   = 2'd1;
    localparam t_op OP_SERIAL = 2'd2;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_CHECK = 3'd0,
        PH_REV   = 3'd1,
        PH_FWD   = 3'd2,
        PH_COUNT = 3'd3,
        PH_HOME  = 3'd4
    } t_phase;

    localparam int LEN_W  = 3;
    localparam int HOLE_W = 4;

    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [HOLE_W-1:0] t_hole;

    // Hole count wraps to zero once it would pass this value
    localparam t_hole HOLE_MAX = 4'd10;
    localparam t_len  SERIAL_LEN_RESET = 3'd3;

    // One input word
    typedef struct packed {
        t_op  operation;
        logic stop_request;
        logic control_pin;
        logic limit_pin;
        logic home_pin;
        logic length_select_low;
        logic length_select_high;
        logic serial_control_value;
    } t_item;

    // One result word
    typedef struct packed {
        logic motor_enable;
        logic drive_forward;
        logic drive_reverse;
        logic status_pin;
        logic stroke_done;
        logic stroke_moving;
        logic serial_active;
    } t_result;

endpackage

### rtl/ess_in_reg.sv
// Input register stage: holds one accepted word until the core takes it.
module ess_in_reg
    import ess_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    logic  r_valid;
    t_item r_item;

    // Stall only while a held word cannot move on this cycle
    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Payload loads on acceptance only
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/ess_core.sv
// Sequencer state, stroke length register and the per-word update logic.
module ess_core
    import ess_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_wr_en,
    input  t_len    i_cfg_wr_data,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    t_phase r_phase, n_phase;
    t_hole  r_hole, n_hole;
    t_len   r_serial_len;
    logic   r_serial, n_serial;
    logic   r_done, n_done;
    logic   r_moving, n_moving;
    logic   r_en, n_en;
    logic   r_fwd, n_fwd;
    logic   r_rev, n_rev;
    logic   r_status, n_status;

    logic   at_home;
    logic   request;
    t_len   len;
    t_hole  len_plus;
    t_hole  hole_inc;

    assign at_home  = i_item.limit_pin && i_item.home_pin;
    assign request  = i_item.control_pin || r_serial;
    assign hole_inc = r_hole + t_hole'(1);

    // Stroke length: register under serial control, else the select pins
    always_comb begin
        if (r_serial) begin
            len = r_serial_len;
        end else begin
            len = t_len'(1) + t_len'(i_item.length_select_low)
                + {1'b0, i_item.length_select_high, 1'b0};
        end
        len_plus = t_hole'(len) + t_hole'(1);
    end

    // Next state for one word
    always_comb begin
        n_phase  = r_phase;
        n_hole   = r_hole;
        n_serial = r_serial;
        n_done   = r_done;
        n_moving = r_moving;
        n_en     = r_en;
        n_fwd    = r_fwd;
        n_rev    = r_rev;
        n_status = r_status;
        unique case (i_item.operation)
            OP_TICK: begin
                if (i_item.stop_request) begin
                    n_en     = 1'b0;
                    n_fwd    = 1'b0;
                    n_rev    = 1'b0;
                    n_status = 1'b0;
                    n_done   = 1'b0;
                    n_moving = 1'b0;
                    n_serial = 1'b0;
                end else if (!request) begin
                    // idle tick: park at home or back toward it
                    n_en     = 1'b1;
                    n_moving = 1'b0;
                    n_status = 1'b0;
                    n_phase  = PH_CHECK;
                    n_fwd    = 1'b0;
                    if (at_home) begin
                        n_rev = 1'b0;
                    end else begin
                        n_hole = '0;
                        n_rev  = 1'b1;
                    end
                end else begin
                    n_en     = 1'b1;
                    n_done   = 1'b0;
                    n_moving = 1'b1;
                    unique case (r_phase)
                        PH_CHECK: begin
                            n_hole  = '0;
                            n_phase = at_home ? PH_FWD : PH_REV;
                        end
                        PH_REV: begin
                            n_hole  = '0;
                            n_fwd   = 1'b0;
                            n_rev   = 1'b1;
                            n_phase = PH_CHECK;
                        end
                        PH_FWD: begin
                            n_rev   = 1'b0;
                            n_fwd   = 1'b1;
                            n_phase = PH_COUNT;
                        end
                        PH_COUNT: begin
                            n_phase = (r_hole >= len_plus) ? PH_HOME : PH_FWD;
                        end
                        PH_HOME: begin
                            if (at_home) begin
                                n_serial = 1'b0;
                                n_done   = 1'b1;
                                n_moving = 1'b0;
                                n_status = 1'b1;
                                n_fwd    = 1'b0;
                                n_rev    = 1'b0;
                            end else begin
                                n_hole = '0;
                                n_fwd  = 1'b0;
                                n_rev  = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_HOLE: begin
                n_hole = (hole_inc > HOLE_MAX) ? '0 : hole_inc;
            end
            OP_SERIAL: begin
                n_serial = i_item.serial_control_value;
            end
            default: begin
            end
        endcase
    end

    // Result shows the state after the word
    always_comb begin
        o_result.motor_enable  = n_en;
        o_result.drive_forward = n_fwd;
        o_result.drive_reverse = n_rev;
        o_result.status_pin    = n_status;
        o_result.stroke_done   = n_done;
        o_result.stroke_moving = n_moving;
        o_result.serial_active = n_serial;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CHECK;
            r_hole   <= '0;
            r_serial <= 1'b0;
            r_done   <= 1'b0;
            r_moving <= 1'b0;
            r_en     <= 1'b0;
            r_fwd    <= 1'b0;
            r_rev    <= 1'b0;
            r_status <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_hole   <= n_hole;
            r_serial <= n_serial;
            r_done   <= n_done;
            r_moving <= n_moving;
            r_en     <= n_en;
            r_fwd    <= n_fwd;
            r_rev    <= n_rev;
            r_status <= n_status;
        end
    end

    // Serial stroke length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_serial_len <= SERIAL_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_serial_len <= i_cfg_wr_data;
        end
    end

endmodule

### rtl/ejector_stroke_sequencer.sv
// Top level of the ejector stroke sequencer: input stage, core and result register.
//
// Each accepted word (control tick, hole edge or serial flag write) yields exactly one
// result word holding the latched drive outputs and host flags after that word. The
// block takes one word per cycle while the input side is not stalled. A word sits in
// the input register while the combinational update of phase, hole count and flags
// is computed; its result then loads into the result register once that is free,
// and is presented on the output from there. The input side stalls only while a word
// is held and the result register is full and stalled. The serial stroke length
// register may be written at any time the block is idle.
module ejector_stroke_sequencer
    import ess_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_wr_data,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_operation,
    input  logic       i_stop_request,
    input  logic       i_control_pin,
    input  logic       i_limit_pin,
    input  logic       i_home_pin,
    input  logic       i_length_select_low,
    input  logic       i_length_select_high,
    input  logic       i_serial_control_value,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_motor_enable,
    output logic       o_drive_forward,
    output logic       o_drive_reverse,
    output logic       o_status_pin,
    output logic       o_stroke_done,
    output logic       o_stroke_moving,
    output logic       o_serial_active
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_free;
    logic    step;
    t_result core_result;
    logic    r_out_valid;
    t_result r_out;

    assign in_item.operation            = i_operation;
    assign in_item.stop_request         = i_stop_request;
    assign in_item.control_pin          = i_control_pin;
    assign in_item.limit_pin            = i_limit_pin;
    assign in_item.home_pin             = i_home_pin;
    assign in_item.length_select_low    = i_length_select_low;
    assign in_item.length_select_high   = i_length_select_high;
    assign in_item.serial_control_value = i_serial_control_value;

    // Result register can take a word when empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;
    assign step     = held_valid && out_free;

    ess_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .o_stall (o_in_stall),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_take  (out_free)
    );

    ess_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_item        (held_item),
        .o_result      (core_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_motor_enable  = r_out.motor_enable;
    assign o_drive_forward = r_out.drive_forward;
    assign o_drive_reverse = r_out.drive_reverse;
    assign o_status_pin    = r_out.status_pin;
    assign o_stroke_done   = r_out.stroke_done;
    assign o_stroke_moving = r_out.stroke_moving;
    assign o_serial_active = r_out.serial_active;

endmodule
